>>> hw/rtl/gsbd_pkg.sv
// Shared widths, request and status codes, and the result record of the graph store.
package gsbd_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int ID_W          = 64;
    localparam int HOP_W         = 6;
    localparam int MODE_W        = 3;
    localparam int STAT_W        = 3;
    // status, present, hop, neighbor id, neighbor valid, padded to bytes
    localparam int OUT_DATA_W    = 80;

    // request modes
    localparam logic [MODE_W-1:0] MD_ADD_NODE = 3'd0;
    localparam logic [MODE_W-1:0] MD_ADD_EDGE = 3'd1;
    localparam logic [MODE_W-1:0] MD_REM_NODE = 3'd2;
    localparam logic [MODE_W-1:0] MD_REM_EDGE = 3'd3;
    localparam logic [MODE_W-1:0] MD_NODE_Q   = 3'd4;
    localparam logic [MODE_W-1:0] MD_EDGE_Q   = 3'd5;
    localparam logic [MODE_W-1:0] MD_NEIGH    = 3'd6;
    localparam logic [MODE_W-1:0] MD_DIST     = 3'd7;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_SAME      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_PATH   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              present;
        logic [HOP_W-1:0]  hop;
        logic [ID_W-1:0]   nid;
        logic              nvalid;
        logic              last;
    } t_res;

    // single-beat result with no neighbor payload
    function automatic t_res mk_res(input logic [STAT_W-1:0] st, input logic pr,
                                    input logic [HOP_W-1:0] hp);
        t_res r;
        r.status  = st;
        r.present = pr;
        r.hop     = hp;
        r.nid     = '0;
        r.nvalid  = 1'b0;
        r.last    = 1'b1;
        return r;
    endfunction

endpackage

>>> hw/rtl/graph_store_bfs_distance.sv
// Graph store: id table, adjacency matrix and breadth-first hop search on local memories.
//
//  channel  dir  beat contents
//  s_axis   in   tuser: mode; tdata: node_a, node_b
//  m_axis   out  tdata: status, present, hop_distance, neighbor_id, neighbor_valid; tlast
//
// One request at a time. Every request first sweeps the id table, one slot per cycle,
// then the node/edge op runs; remove node sweeps the adjacency memory, reading then writing
// each row; neighbors are read and returned as one result beat per neighbor; a distance
// search dequeues a node, reads its row and hop count, then enqueues each new neighbor.
// Reset clears slot valid bits and control; memories need no clearing pass.
// Output stalls hold the result register; a new request is taken once the last
// result is in the output register.
module graph_store_bfs_distance #(
    parameter int MAX_NODES = gsbd_pkg::MAX_NODES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*gsbd_pkg::ID_W-1:0]        s_axis_tdata,  // node_a, node_b
    input  logic [gsbd_pkg::MODE_W-1:0]        s_axis_tuser,  // mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, present, hop_distance, neighbor_id, neighbor_valid, zero pad
    output logic [gsbd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import gsbd_pkg::*;

    localparam int SW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_WOUT  = 4'd3;
    localparam logic [3:0] S_E_A   = 4'd4;
    localparam logic [3:0] S_E_B   = 4'd5;
    localparam logic [3:0] S_RM_RD = 4'd6;
    localparam logic [3:0] S_RM_WR = 4'd7;
    localparam logic [3:0] S_N_ROW = 4'd8;
    localparam logic [3:0] S_N_PCK = 4'd9;
    localparam logic [3:0] S_N_ID  = 4'd10;
    localparam logic [3:0] S_B_Q   = 4'd11;
    localparam logic [3:0] S_B_U   = 4'd12;
    localparam logic [3:0] S_B_ROW = 4'd13;
    localparam logic [3:0] S_B_ENQ = 4'd14;

    // memories
    logic [ID_W-1:0]      id_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [HOP_W-1:0]     hop_mem [MAX_NODES];
    logic [SW-1:0]        que_mem [MAX_NODES];

    logic [ID_W-1:0]      r_id_q;
    logic [MAX_NODES-1:0] r_adj_q;
    logic [HOP_W-1:0]     r_hop_q;
    logic [SW-1:0]        r_que_q;

    logic                 id_we, id_re, adj_we, adj_re, hop_we, hop_re, que_we, que_re;
    logic [SW-1:0]        id_wa, id_ra, adj_wa, adj_ra, hop_wa, hop_ra, que_wa, que_ra;
    logic [MAX_NODES-1:0] adj_wd;
    logic [HOP_W-1:0]     hop_wd;
    logic [SW-1:0]        que_wd;

    // control and request registers
    logic [3:0]           r_state, n_state, r_after, n_after;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [ID_W-1:0]      r_a, n_a, r_b, n_b;
    logic [CW-1:0]        r_idx, n_idx, r_head, n_head, r_tail, n_tail;
    logic                 r_chk, n_chk, r_fa, n_fa, r_fb, n_fb;
    logic [SW-1:0]        r_chk_idx, n_chk_idx, r_sa, n_sa, r_sb, n_sb;
    logic [MAX_NODES-1:0] r_valid, n_valid, r_seen, n_seen, r_pend, n_pend;
    logic [HOP_W-1:0]     r_hopn, n_hopn;
    t_res                 r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;

    logic [MAX_NODES-1:0] bit_sa, bit_sb, new_bits;
    logic                 free_ok, pend_ok;
    logic [SW-1:0]        free_idx, pend_idx;
    logic                 out_free;

    // lowest set bit of a row
    function automatic logic [SW:0] low_bit(input logic [MAX_NODES-1:0] v);
        logic [SW:0] r;
        r = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, SW'(i)};
            end
        end
        return r;
    endfunction

    assign bit_sa   = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_sa;
    assign bit_sb   = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_sb;
    assign new_bits = r_adj_q & ~r_seen;
    assign {free_ok, free_idx} = low_bit(~r_valid);
    assign {pend_ok, pend_idx} = low_bit(r_pend);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // sequencer
    always_comb begin
        n_state = r_state;   n_after = r_after;   n_mode = r_mode;
        n_a = r_a;           n_b = r_b;           n_idx = r_idx;
        n_head = r_head;     n_tail = r_tail;     n_chk = 1'b0;
        n_chk_idx = r_chk_idx;
        n_fa = r_fa;         n_fb = r_fb;         n_sa = r_sa;     n_sb = r_sb;
        n_valid = r_valid;   n_seen = r_seen;     n_pend = r_pend;
        n_hopn = r_hopn;     n_res = r_res;
        n_out_valid = r_out_valid; n_out_data = r_out_data; n_out_last = r_out_last;
        id_we = 1'b0;  id_wa = r_sa;  id_re = 1'b0;  id_ra = r_sa;
        adj_we = 1'b0; adj_wa = r_sa; adj_wd = '0;   adj_re = 1'b0; adj_ra = r_sa;
        hop_we = 1'b0; hop_wa = r_sa; hop_wd = '0;   hop_re = 1'b0; hop_ra = r_sa;
        que_we = 1'b0; que_wa = r_sa; que_wd = r_sa; que_re = 1'b0; que_ra = r_sa;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_a     = s_axis_tdata[ID_W-1:0];
                    n_b     = s_axis_tdata[2*ID_W-1:ID_W];
                    n_idx   = '0;
                    n_fa    = 1'b0;
                    n_fb    = 1'b0;
                    n_state = S_LOOK;
                end
            end
            // id table sweep: read one slot, compare it the next cycle
            S_LOOK: begin
                if (r_chk && r_valid[r_chk_idx]) begin
                    if (!r_fa && r_id_q == r_a) begin
                        n_fa = 1'b1;
                        n_sa = r_chk_idx;
                    end
                    if (!r_fb && r_id_q == r_b) begin
                        n_fb = 1'b1;
                        n_sb = r_chk_idx;
                    end
                end
                if (r_idx != CW'(MAX_NODES)) begin
                    id_re     = 1'b1;
                    id_ra     = r_idx[SW-1:0];
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[SW-1:0];
                    n_idx     = r_idx + 1'b1;
                end else if (!r_chk) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_WOUT;
                n_after = S_IDLE;
                case (r_mode)
                    MD_ADD_NODE: begin
                        if (r_fa) begin
                            n_res = mk_res(ST_EXISTS, 1'b0, '0);
                        end else if (!free_ok) begin
                            n_res = mk_res(ST_FULL, 1'b0, '0);
                        end else begin
                            id_we = 1'b1;
                            id_wa = free_idx;
                            adj_we = 1'b1;
                            adj_wa = free_idx;
                            adj_wd = '0;
                            n_valid[free_idx] = 1'b1;
                            n_res = mk_res(ST_OK, 1'b0, '0);
                        end
                    end
                    MD_ADD_EDGE, MD_EDGE_Q: begin
                        if (!r_fa || !r_fb) begin
                            n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                        end else if (r_sa == r_sb) begin
                            n_res = mk_res(ST_SAME, 1'b0, '0);
                        end else begin
                            adj_re  = 1'b1;
                            n_state = S_E_A;
                        end
                    end
                    MD_REM_NODE: begin
                        if (!r_fa) begin
                            n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                        end else begin
                            n_valid[r_sa] = 1'b0;
                            n_idx   = '0;
                            n_state = S_RM_RD;
                        end
                    end
                    MD_REM_EDGE: begin
                        if (!r_fa || !r_fb) begin
                            n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                        end else begin
                            adj_re  = 1'b1;
                            n_state = S_E_A;
                        end
                    end
                    MD_NODE_Q: begin
                        n_res = mk_res(ST_OK, r_fa, '0);
                    end
                    MD_NEIGH: begin
                        if (!r_fa) begin
                            n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                        end else begin
                            adj_re  = 1'b1;
                            n_state = S_N_ROW;
                        end
                    end
                    default: begin
                        if (!r_fa || !r_fb) begin
                            n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                        end else if (r_sa == r_sb) begin
                            n_res = mk_res(ST_OK, 1'b0, '0);
                        end else begin
                            // seed the search with node a
                            hop_we  = 1'b1;
                            hop_wd  = '0;
                            que_we  = 1'b1;
                            que_wa  = '0;
                            que_wd  = r_sa;
                            n_seen  = bit_sa;
                            n_head  = '0;
                            n_tail  = CW'(1);
                            n_state = S_B_Q;
                        end
                    end
                endcase
            end
            // hand the staged result to the output register
            S_WOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, r_res.nvalid, r_res.nid, r_res.hop,
                                   r_res.present, r_res.status};
                    n_out_last  = r_res.last;
                    n_state     = r_after;
                end
            end
            // row a in hand
            S_E_A: begin
                n_state = S_WOUT;
                n_after = S_IDLE;
                if (r_mode == MD_EDGE_Q) begin
                    n_res = mk_res(ST_OK, r_adj_q[r_sb], '0);
                end else if (r_mode == MD_ADD_EDGE && r_adj_q[r_sb]) begin
                    n_res = mk_res(ST_EXISTS, 1'b0, '0);
                end else if (r_mode == MD_REM_EDGE && !r_adj_q[r_sb]) begin
                    n_res = mk_res(ST_NOT_FOUND, 1'b0, '0);
                end else begin
                    adj_we  = 1'b1;
                    adj_wd  = (r_mode == MD_ADD_EDGE) ? (r_adj_q | bit_sb)
                                                      : (r_adj_q & ~bit_sb);
                    adj_re  = 1'b1;
                    adj_ra  = r_sb;
                    n_state = S_E_B;
                end
            end
            // row b in hand
            S_E_B: begin
                adj_we  = 1'b1;
                adj_wa  = r_sb;
                adj_wd  = (r_mode == MD_ADD_EDGE) ? (r_adj_q | bit_sa)
                                                  : (r_adj_q & ~bit_sa);
                n_res   = mk_res(ST_OK, 1'b0, '0);
                n_state = S_WOUT;
                n_after = S_IDLE;
            end
            // column clear sweep for a removed node
            S_RM_RD: begin
                if (r_idx == CW'(MAX_NODES)) begin
                    n_res   = mk_res(ST_OK, 1'b0, '0);
                    n_state = S_WOUT;
                    n_after = S_IDLE;
                end else begin
                    adj_re  = 1'b1;
                    adj_ra  = r_idx[SW-1:0];
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                adj_we  = 1'b1;
                adj_wa  = r_idx[SW-1:0];
                adj_wd  = (r_idx[SW-1:0] == r_sa) ? '0 : (r_adj_q & ~bit_sa);
                n_idx   = r_idx + 1'b1;
                n_state = S_RM_RD;
            end
            // neighbor listing
            S_N_ROW: begin
                n_pend = r_adj_q & r_valid;
                if ((r_adj_q & r_valid) == '0) begin
                    n_res   = mk_res(ST_OK, 1'b0, '0);
                    n_state = S_WOUT;
                    n_after = S_IDLE;
                end else begin
                    n_state = S_N_PCK;
                end
            end
            S_N_PCK: begin
                id_re            = 1'b1;
                id_ra            = pend_idx;
                n_pend[pend_idx] = 1'b0;
                n_state          = S_N_ID;
            end
            S_N_ID: begin
                n_res        = mk_res(ST_OK, 1'b0, '0);
                n_res.nid    = r_id_q;
                n_res.nvalid = 1'b1;
                n_res.last   = (r_pend == '0);
                n_state      = S_WOUT;
                n_after      = (r_pend == '0) ? S_IDLE : S_N_PCK;
            end
            // breadth-first search
            S_B_Q: begin
                if (r_head == r_tail) begin
                    n_res   = mk_res(ST_NO_PATH, 1'b0, '0);
                    n_state = S_WOUT;
                    n_after = S_IDLE;
                end else begin
                    que_re  = 1'b1;
                    que_ra  = r_head[SW-1:0];
                    n_head  = r_head + 1'b1;
                    n_state = S_B_U;
                end
            end
            S_B_U: begin
                adj_re  = 1'b1;
                adj_ra  = r_que_q;
                hop_re  = 1'b1;
                hop_ra  = r_que_q;
                n_state = S_B_ROW;
            end
            S_B_ROW: begin
                if (new_bits[r_sb]) begin
                    n_res   = mk_res(ST_OK, 1'b0, r_hop_q + 1'b1);
                    n_state = S_WOUT;
                    n_after = S_IDLE;
                end else begin
                    n_seen  = r_seen | new_bits;
                    n_pend  = new_bits;
                    n_hopn  = r_hop_q + 1'b1;
                    n_state = S_B_ENQ;
                end
            end
            S_B_ENQ: begin
                if (!pend_ok) begin
                    n_state = S_B_Q;
                end else begin
                    que_we           = 1'b1;
                    que_wa           = r_tail[SW-1:0];
                    que_wd           = pend_idx;
                    hop_we           = 1'b1;
                    hop_wa           = pend_idx;
                    hop_wd           = r_hopn;
                    n_tail           = r_tail + 1'b1;
                    n_pend[pend_idx] = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_idx       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_a        <= n_a;
        r_b        <= n_b;
        r_chk_idx  <= n_chk_idx;
        r_fa       <= n_fa;
        r_fb       <= n_fb;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_seen     <= n_seen;
        r_pend     <= n_pend;
        r_hopn     <= n_hopn;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // id table
    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[id_wa] <= r_a;
        end
        if (id_re) begin
            r_id_q <= id_mem[id_ra];
        end
    end

    // adjacency rows
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            adj_mem[adj_wa] <= adj_wd;
        end
        if (adj_re) begin
            r_adj_q <= adj_mem[adj_ra];
        end
    end

    // hop counts
    always_ff @(posedge i_clk) begin
        if (hop_we) begin
            hop_mem[hop_wa] <= hop_wd;
        end
        if (hop_re) begin
            r_hop_q <= hop_mem[hop_ra];
        end
    end

    // search queue
    always_ff @(posedge i_clk) begin
        if (que_we) begin
            que_mem[que_wa] <= que_wd;
        end
        if (que_re) begin
            r_que_q <= que_mem[que_ra];
        end
    end

    // queue never outgrows the node count
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CW'(MAX_NODES))
        else $error("search queue tail past node count");

    // dequeue never passes enqueue
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_Q) |-> (r_head <= r_tail))
        else $error("search queue head past tail");

    // an accepted request always starts with the id sweep
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_LOOK))
        else $error("request accepted without id lookup");

    // a neighbor beat always names a live slot's id pick
    a_pick_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_N_PCK) |-> (pend_ok && r_valid[pend_idx]))
        else $error("neighbor pick on empty or dead slot");

endmodule
